// File: sv/ptu_pkg.sv
// Package for the Polish-letter CP1250/UTF-8 transcoder.
// Holds the letter tables, lead-byte codes and shared types; no dependencies.
package ptu_pkg;

    // Number of letters in the table
    localparam int LETTER_COUNT = 18;

    // UTF-8 lead bytes used by the Polish letters
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C5 = 8'hC5;

    // Direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Windows-1250 codes, upper case then lower case
    localparam logic [7:0] WIN_CODE [LETTER_COUNT] = '{
        8'hA5, 8'hC6, 8'hCA, 8'hA3, 8'hD1, 8'hD3, 8'h8C, 8'h8F, 8'hAF,
        8'hB9, 8'hE6, 8'hEA, 8'hB3, 8'hF1, 8'hF3, 8'h9C, 8'h9F, 8'hBF
    };
    localparam logic [7:0] UTF_LEAD [LETTER_COUNT] = '{
        8'hC4, 8'hC4, 8'hC4, 8'hC5, 8'hC5, 8'hC3, 8'hC5, 8'hC5, 8'hC5,
        8'hC4, 8'hC4, 8'hC4, 8'hC5, 8'hC5, 8'hC3, 8'hC5, 8'hC5, 8'hC5
    };
    localparam logic [7:0] UTF_TRAIL [LETTER_COUNT] = '{
        8'h84, 8'h86, 8'h98, 8'h81, 8'h83, 8'h93, 8'h9A, 8'hB9, 8'hBB,
        8'h85, 8'h87, 8'h99, 8'h82, 8'h84, 8'hB3, 8'h9B, 8'hBA, 8'hBC
    };

    // Output run of zero, one or two bytes caused by one input word
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_run;

    // Held UTF-8 lead byte
    typedef struct packed {
        logic       held;
        logic [7:0] lead;
    } t_lead;

endpackage

// File: sv/ptu_convert.sv
// Conversion logic: table search and run/lead-state decision for one byte.
// Depends on ptu_pkg.
module ptu_convert #(
    parameter int ENTRIES = 18
) (
    input  logic            i_dir,
    input  ptu_pkg::t_lead  i_lead,
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    output ptu_pkg::t_run   o_run,
    output ptu_pkg::t_lead  o_lead
);

    localparam int LIMIT = (ENTRIES < ptu_pkg::LETTER_COUNT) ? ENTRIES : ptu_pkg::LETTER_COUNT;

    logic       enc_hit;
    logic [7:0] enc_lead;
    logic [7:0] enc_trail;
    logic       dec_hit;
    logic [7:0] dec_win;
    logic       is_lead;

    // Search the table, first match wins
    always_comb begin
        enc_hit   = 1'b0;
        enc_lead  = 8'h00;
        enc_trail = 8'h00;
        dec_hit   = 1'b0;
        dec_win   = 8'h00;
        for (int i = LIMIT - 1; i >= 0; i--) begin
            if (ptu_pkg::WIN_CODE[i] == i_byte) begin
                enc_hit   = 1'b1;
                enc_lead  = ptu_pkg::UTF_LEAD[i];
                enc_trail = ptu_pkg::UTF_TRAIL[i];
            end
            if (ptu_pkg::UTF_LEAD[i] == i_lead.lead && ptu_pkg::UTF_TRAIL[i] == i_byte) begin
                dec_hit = 1'b1;
                dec_win = ptu_pkg::WIN_CODE[i];
            end
        end
    end

    assign is_lead = (i_byte == ptu_pkg::LEAD_C3) || (i_byte == ptu_pkg::LEAD_C4)
                  || (i_byte == ptu_pkg::LEAD_C5);

    // Choose the output run and the next lead state
    always_comb begin
        o_run  = '{cnt: 2'd1, b0: i_byte, b1: 8'h00};
        o_lead = '{held: 1'b0, lead: 8'h00};
        if (i_dir == ptu_pkg::DIR_ENCODE) begin
            if (enc_hit) begin
                o_run = '{cnt: 2'd2, b0: enc_lead, b1: enc_trail};
            end
        end else if (i_lead.held) begin
            if (dec_hit) begin
                o_run = '{cnt: 2'd1, b0: dec_win, b1: 8'h00};
            end else begin
                o_run = '{cnt: 2'd2, b0: i_lead.lead, b1: i_byte};
            end
        end else if (is_lead && !i_eos) begin
            o_run  = '{cnt: 2'd0, b0: i_byte, b1: 8'h00};
            o_lead = '{held: 1'b1, lead: i_byte};
        end
    end

endmodule

// File: sv/ptu_obuf.sv
// Output buffer: holds one run of up to two bytes and serializes it.
// Depends on ptu_pkg.
module ptu_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ptu_pkg::t_run  i_run,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    logic [1:0] r_cnt;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    // Take a new run once the current one drains this cycle
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_byte  = r_b0;
    assign o_last  = (r_cnt == 2'd1);

    // Load a run, or advance to the second byte on a pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_run.cnt;
            r_b0  <= i_run.b0;
            r_b1  <= i_run.b1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_b0  <= r_b1;
        end
    end

endmodule

// File: sv/polish_cp1250_utf8_transcoder.sv
// Polish-letter transcoder between Windows-1250 and UTF-8 (top level).
// Depends on ptu_pkg, ptu_convert and ptu_obuf.
//
// Each input word passes an input register, then the table search, into a two-byte
// output buffer. A word that yields two bytes leaves one byte at a time through the
// single-byte output port; a held UTF-8 lead byte yields nothing. The first output
// byte of a word is driven from the output buffer register, after the input register.
// The direction register (0 encode to UTF-8, 1 decode) is written through the
// configuration port, which is always ready; a write also drops any held lead byte
// and must only happen while the block is idle.
module polish_cp1250_utf8_transcoder #(
    parameter int TABLE_ENTRIES = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_direction
);

    logic           r_dir;
    logic           r_in_vld;
    logic [7:0]     r_in_byte;
    logic           r_in_eos;
    ptu_pkg::t_lead r_lead;
    ptu_pkg::t_lead n_lead;
    ptu_pkg::t_run  run;
    logic           obuf_ready;
    logic           consume;
    logic           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Process the registered word when its results fit in the output buffer
    assign consume    = r_in_vld && (obuf_ready || (run.cnt == 2'd0));
    assign o_in_stall = r_in_vld && !consume;

    ptu_convert #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_convert (
        .i_dir  (r_dir),
        .i_lead (r_lead),
        .i_byte (r_in_byte),
        .i_eos  (r_in_eos),
        .o_run  (run),
        .o_lead (n_lead)
    );

    ptu_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && (run.cnt != 2'd0)),
        .i_run   (run),
        .o_ready (obuf_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_byte  (o_out_byte),
        .o_last  (o_last_of_run)
    );

    // Capture input words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld  <= 1'b1;
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_stream;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    // Hold direction and lead state; a direction write drops the lead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= ptu_pkg::DIR_ENCODE;
            r_lead <= '{held: 1'b0, lead: 8'h00};
        end else if (cfg_wr) begin
            r_dir  <= i_cfg_direction;
            r_lead <= '{held: 1'b0, lead: 8'h00};
        end else if (consume) begin
            r_lead <= n_lead;
        end
    end

    // A lead byte is only ever held while decoding
    a_held_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead.held |-> (r_dir == ptu_pkg::DIR_DECODE))
        else $error("lead byte held in encode direction");

    // A held byte is always one of the three lead codes
    a_held_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead.held |-> ((r_lead.lead == ptu_pkg::LEAD_C3) || (r_lead.lead == ptu_pkg::LEAD_C4)
                      || (r_lead.lead == ptu_pkg::LEAD_C5)))
        else $error("held byte is not a lead code");

    // Nothing stays held after the last word of a stream
    a_eos_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_eos) |=> !r_lead.held)
        else $error("lead byte held after end of stream");

    // A word that yields nothing never stalls the input
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (run.cnt == 2'd0)) |-> !o_in_stall)
        else $error("empty run stalled the input");

endmodule

// File: verif/polish_cp1250_utf8_transcoder_tb.sv
// Testbench for polish_cp1250_utf8_transcoder: drives byte words in both directions
// and checks every output byte against a local transcoding predictor.
// Depends on ptu_pkg and the transcoder RTL.
`timescale 1ns / 100ps

module polish_cp1250_utf8_transcoder_tb;

    localparam int TABLE_ENTRIES = 18;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_stream;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_direction;

    // Predictor state: direction and the held UTF-8 lead
    logic       model_dir;
    logic       model_held;
    logic [7:0] model_lead;

    t_out_word  expected_bytes[$];
    int         mismatch_count;

    // Idle controls shared by the source and the sink
    bit         src_gaps;
    bit         sink_quiet;

    polish_cp1250_utf8_transcoder #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_stream(i_end_of_stream),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_direction(i_cfg_direction)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        #15_000_000;
        $display("polish_cp1250_utf8_transcoder_tb NOT OK");
        $finish;
    end

    function automatic bit is_lead(input logic [7:0] b);
        return (b == ptu_pkg::LEAD_C3) || (b == ptu_pkg::LEAD_C4)
            || (b == ptu_pkg::LEAD_C5);
    endfunction

    function automatic void queue_run(input int cnt, input logic [7:0] a,
                                      input logic [7:0] b);
        t_out_word w;
        w.data = a;
        w.last = (cnt == 1);
        expected_bytes.push_back(w);
        if (cnt == 2) begin
            w.data = b;
            w.last = 1'b1;
            expected_bytes.push_back(w);
        end
    endfunction

    // Predict the output bytes of one accepted word and advance the lead state
    task automatic transcode_word(input logic [7:0] b, input logic eos);
        int k;
        logic [7:0] lead;
        k = -1;
        if (model_dir == ptu_pkg::DIR_ENCODE) begin
            for (int i = 0; i < TABLE_ENTRIES && i < ptu_pkg::LETTER_COUNT; i++)
                if (k < 0 && ptu_pkg::WIN_CODE[i] == b) k = i;
            if (k >= 0) queue_run(2, ptu_pkg::UTF_LEAD[k], ptu_pkg::UTF_TRAIL[k]);
            else queue_run(1, b, 8'h00);
        end else if (model_held) begin
            lead = model_lead;
            model_held = 1'b0;
            model_lead = 8'h00;
            for (int i = 0; i < TABLE_ENTRIES && i < ptu_pkg::LETTER_COUNT; i++)
                if (k < 0 && ptu_pkg::UTF_LEAD[i] == lead && ptu_pkg::UTF_TRAIL[i] == b)
                    k = i;
            if (k >= 0) queue_run(1, ptu_pkg::WIN_CODE[k], 8'h00);
            else queue_run(2, lead, b);
        end else if (is_lead(b) && !eos) begin
            model_held = 1'b1;
            model_lead = b;
        end else begin
            queue_run(1, b, 8'h00);
        end
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!src_gaps) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Send one word; returns at the edge that accepted it
    task automatic send_word(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        transcode_word(b, eos);
    endtask

    // Drop valid, wait for every expected byte, then let the pipeline settle
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the direction register; the block drops any held lead
    task automatic write_direction(input logic dir);
        i_cfg_valid     <= 1'b1;
        i_cfg_direction <= dir;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_dir  = dir;
        model_held = 1'b0;
        model_lead = 8'h00;
        @(posedge i_clk);
    endtask

    function automatic logic random_eos(input int one_in);
        return ($urandom_range(1, one_in) == 1);
    endfunction

    // One encode-side word: table letters, leads and raw bytes
    task automatic send_encode_word();
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 50) b = ptu_pkg::WIN_CODE[$urandom_range(0, ptu_pkg::LETTER_COUNT - 1)];
        else if (r < 65) b = ptu_pkg::LEAD_C3 + 8'($urandom_range(0, 2));
        else b = 8'($urandom_range(0, 255));
        send_word(b, random_eos(10));
    endtask

    // One decode-side sequence, mostly well-formed letters; returns words sent
    task automatic send_decode_chunk(output int sent);
        int r;
        int k;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, ptu_pkg::LETTER_COUNT - 1);
        if (r < 55) begin
            send_word(ptu_pkg::UTF_LEAD[k], 1'b0);
            send_word(ptu_pkg::UTF_TRAIL[k], random_eos(12));
            sent = 2;
        end else if (r < 75) begin
            b = 8'($urandom_range(0, 255));
            if (is_lead(b)) b = b ^ 8'h10;
            send_word(b, random_eos(10));
            sent = 1;
        end else if (r < 85) begin
            send_word(ptu_pkg::UTF_LEAD[k], 1'b0);
            send_word(8'($urandom_range(0, 255)), random_eos(6));
            sent = 2;
        end else if (r < 92) begin
            send_word(ptu_pkg::UTF_LEAD[k], 1'b1);
            sent = 1;
        end else begin
            send_word(8'($urandom_range(0, 255)), random_eos(4));
            sent = 1;
        end
    endtask

    // Extremes, both directions and every lead-byte corner
    task automatic test_directed_cases();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'hBF, 1'b1);
        send_word(ptu_pkg::LEAD_C4, 1'b0);
        settle_idle();
        write_direction(ptu_pkg::DIR_DECODE);
        // matching pair, then a pair closed by end of stream
        send_word(ptu_pkg::LEAD_C4, 1'b0);
        send_word(8'h84, 1'b0);
        send_word(ptu_pkg::LEAD_C5, 1'b0);
        send_word(8'hBC, 1'b1);
        // lead alone at end of stream
        send_word(ptu_pkg::LEAD_C3, 1'b1);
        // lead as second byte of a pair, not held again
        send_word(ptu_pkg::LEAD_C3, 1'b0);
        send_word(ptu_pkg::LEAD_C4, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        // lead with a non-matching trail
        send_word(ptu_pkg::LEAD_C5, 1'b0);
        send_word(8'h00, 1'b0);
        // hold a lead, then discard it with a register write
        send_word(ptu_pkg::LEAD_C4, 1'b0);
        settle_idle();
        write_direction(ptu_pkg::DIR_DECODE);
        send_word(8'h41, 1'b0);
        settle_idle();
    endtask

    task automatic test_encode_stream();
        write_direction(ptu_pkg::DIR_ENCODE);
        repeat (500) send_encode_word();
        settle_idle();
    endtask

    task automatic test_decode_stream();
        int total;
        int n;
        total = 0;
        write_direction(ptu_pkg::DIR_DECODE);
        while (total < 800) begin
            send_decode_chunk(n);
            total += n;
        end
        settle_idle();
    endtask

    // Switch directions, mostly alternating, some phases with no idling on either side
    task automatic test_direction_switching();
        int total;
        int n;
        int words;
        logic dir;
        for (int phase = 0; phase < 8; phase++) begin
            dir = (phase % 3 == 2) ? model_dir : ~model_dir;
            src_gaps   = (phase % 4 != 1);
            sink_quiet = (phase % 4 == 1);
            write_direction(dir);
            words = $urandom_range(40, 90);
            total = 0;
            while (total < words) begin
                if (dir == ptu_pkg::DIR_ENCODE) begin
                    send_encode_word();
                    total++;
                end else begin
                    send_decode_chunk(n);
                    total += n;
                end
            end
            // leave a lead held for the next write to drop
            if (dir == ptu_pkg::DIR_DECODE && phase % 2 == 0)
                send_word(ptu_pkg::LEAD_C3 + 8'($urandom_range(0, 2)), 1'b0);
            settle_idle();
        end
        src_gaps   = 1'b1;
        sink_quiet = 1'b0;
    endtask

    // Sink stall: random free and stalled runs, stalls mostly short
    initial begin : sink_stall
        int left;
        bit stall_now;
        i_out_stall = 1'b0;
        left = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                stall_now = !stall_now;
                if (stall_now)
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(1, 3);
                else
                    left = $urandom_range(1, 10);
            end
            left--;
            i_out_stall <= stall_now && !sink_quiet;
        end
    end

    // Compare each accepted output byte with the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: out_byte expected none actual %02h last %0b", $time,
                         o_out_byte, o_last_of_run);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             want.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b", $time,
                             want.last, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_byte       = 8'h00;
        i_end_of_stream = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_direction = 1'b0;
        model_dir       = ptu_pkg::DIR_ENCODE;
        model_held      = 1'b0;
        model_lead      = 8'h00;
        mismatch_count  = 0;
        src_gaps        = 1'b1;
        sink_quiet      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_directed_cases();
        test_encode_stream();
        test_decode_stream();
        test_direction_switching();
        settle_idle();

        if (mismatch_count == 0)
            $display("polish_cp1250_utf8_transcoder_tb OK");
        else
            $display("polish_cp1250_utf8_transcoder_tb NOT OK");
        $finish;
    end

endmodule
